// File: hw/rtl/rc4_stream_cipher_unit_macros.svh
// -----------------------------------------------------------------------------
// RC4 stream cipher unit - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// -----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_STREAM_CIPHER_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define RC4_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rc4_pkg.sv
// -----------------------------------------------------------------------------
// RC4 package
// Types, constants and the microcode store of the RC4 cipher unit.
// -----------------------------------------------------------------------------
package rc4_pkg;

  localparam int MAX_KEY_BYTES = 256;
  localparam int PERM_DEPTH = 256;

  localparam logic [8:0] KEY_LENGTH_RST = 9'd16;
  localparam logic [9:0] DROP_COUNT_RST = 10'd512;

  // configuration register indexes
  localparam logic CFG_KEY_LENGTH = 1'b0;
  localparam logic CFG_DROP_COUNT = 1'b1;

  typedef enum logic [1:0] {
    A_LOAD  = 2'd0,
    A_SCHED = 2'd1,
    A_DATA  = 2'd2,
    A_NOP   = 2'd3
  } action_e;

  // jump conditions; when false the step counter advances by one, bar dispatch
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_DROP_ZERO,
    C_N_MORE,
    C_DROP_MORE,
    C_OUT_DONE
  } cond_e;

  // permutation read address source
  typedef enum logic [2:0] {
    R_NONE,
    R_I_NEXT,
    R_J_A,
    R_AB,
    R_N,
    R_KK,
    R_N_NEXT
  } rsel_e;

  // permutation write source
  typedef enum logic [2:0] {
    W_NONE,
    W_I_B,
    W_J_A,
    W_N_EFF,
    W_K_T
  } wsel_e;

  typedef logic [3:0] upc_t;

  localparam upc_t U_IDLE  = 4'd0;
  localparam upc_t U_LOAD  = 4'd1;
  localparam upc_t U_SINIT = 4'd2;
  localparam upc_t U_SRD   = 4'd3;
  localparam upc_t U_SMIX  = 4'd4;
  localparam upc_t U_SWRN  = 4'd5;
  localparam upc_t U_SWRK  = 4'd6;
  localparam upc_t U_DCHK  = 4'd7;
  localparam upc_t U_K0    = 4'd8;
  localparam upc_t U_K1    = 4'd9;
  localparam upc_t U_K2    = 4'd10;
  localparam upc_t U_K3    = 4'd11;
  localparam upc_t U_K4    = 4'd12;
  localparam upc_t U_K5    = 4'd13;

  typedef struct packed {
    cond_e  cond;
    upc_t   target;
    rsel_e  rsel;
    wsel_e  wsel;
    logic   ks_init;
    logic   inc_i;
    logic   ld_aj;
    logic   ld_b;
    logic   ld_tk;
    logic   step_n;
    logic   dec_drop;
    logic   key_we;
    logic   out_ld;
  } ctl_t;

  typedef struct packed {
    logic dmode;
    logic drop_zero;
    logic drop_one;
    logic n_last;
  } status_t;

  localparam ctl_t CTL_NOP = '{
    cond: C_NEXT, target: U_IDLE, rsel: R_NONE, wsel: W_NONE,
    ks_init: 1'b0, inc_i: 1'b0, ld_aj: 1'b0, ld_b: 1'b0, ld_tk: 1'b0,
    step_n: 1'b0, dec_drop: 1'b0, key_we: 1'b0, out_ld: 1'b0
  };

  // microcode store
  function automatic ctl_t ucode(input upc_t upc);
    ctl_t w;
    w = CTL_NOP;
    unique case (upc)
      U_IDLE:  w.cond = C_DISPATCH;
      U_LOAD: begin
        w.key_we = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      U_SINIT: w.ks_init = 1'b1;
      U_SRD:   w.rsel = R_N;
      U_SMIX: begin
        w.ld_tk = 1'b1;
        w.rsel  = R_KK;
      end
      U_SWRN:  w.wsel = W_N_EFF;
      U_SWRK: begin
        w.wsel   = W_K_T;
        w.rsel   = R_N_NEXT;
        w.step_n = 1'b1;
        w.cond   = C_N_MORE;
        w.target = U_SMIX;
      end
      U_DCHK: begin
        w.cond   = C_DROP_ZERO;
        w.target = U_IDLE;
      end
      U_K0: begin
        w.inc_i = 1'b1;
        w.rsel  = R_I_NEXT;
      end
      U_K1: begin
        w.ld_aj = 1'b1;
        w.rsel  = R_J_A;
      end
      U_K2: begin
        w.ld_b = 1'b1;
        w.wsel = W_I_B;
      end
      U_K3: begin
        w.wsel     = W_J_A;
        w.rsel     = R_AB;
        w.dec_drop = 1'b1;
        w.cond     = C_DROP_MORE;
        w.target   = U_K0;
      end
      // keep re-reading the keystream entry while the beat waits
      U_K4: begin
        w.out_ld = 1'b1;
        w.rsel   = R_AB;
        w.cond   = C_OUT_DONE;
        w.target = U_IDLE;
      end
      U_K5: begin
        w.rsel   = R_AB;
        w.cond   = C_ALWAYS;
        w.target = U_K4;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/rc4_ram.sv
// -----------------------------------------------------------------------------
// RC4 generic RAM
// One write port, one read port, registered read with write-through.
// -----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rc4_seq.sv
// -----------------------------------------------------------------------------
// RC4 microsequencer
// Step counter over the microcode store with conditional jumps.
// -----------------------------------------------------------------------------
module rc4_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [1:0]       action_i,
  input  rc4_pkg::status_t st_i,
  input  logic             out_free_i,
  output rc4_pkg::ctl_t    ctl_o,
  output logic             idle_o
);

  rc4_pkg::upc_t upc_q, upc_d;
  rc4_pkg::ctl_t ctl;
  logic          take;

  assign ctl = rc4_pkg::ucode(upc_q);

  always_comb begin
    take = 1'b0;
    upc_d = upc_q + rc4_pkg::upc_t'(1);
    unique case (ctl.cond)
      rc4_pkg::C_NEXT:      take = 1'b0;
      rc4_pkg::C_ALWAYS:    take = 1'b1;
      rc4_pkg::C_DROP_ZERO: take = st_i.drop_zero;
      rc4_pkg::C_N_MORE:    take = !st_i.n_last;
      rc4_pkg::C_DROP_MORE: take = !st_i.dmode && !st_i.drop_one;
      rc4_pkg::C_OUT_DONE:  take = !st_i.dmode || out_free_i;
      rc4_pkg::C_DISPATCH:  take = 1'b0;
      default:              take = 1'b0;
    endcase
    if (take) begin
      upc_d = ctl.target;
    end
    if (ctl.cond == rc4_pkg::C_DISPATCH) begin
      upc_d = rc4_pkg::U_IDLE;
      if (acc_i) begin
        unique case (action_i)
          rc4_pkg::A_LOAD:  upc_d = rc4_pkg::U_LOAD;
          rc4_pkg::A_SCHED: upc_d = rc4_pkg::U_SINIT;
          rc4_pkg::A_DATA:  upc_d = rc4_pkg::U_K0;
          default:          upc_d = rc4_pkg::U_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= rc4_pkg::U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctl_o  = ctl;
  assign idle_o = (upc_q == rc4_pkg::U_IDLE);

endmodule

// File: hw/rtl/rc4_dp.sv
// -----------------------------------------------------------------------------
// RC4 datapath
// Permutation and key stores, index registers and counters.
// -----------------------------------------------------------------------------
module rc4_dp #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rc4_pkg::ctl_t    ctl_i,
  input  logic             acc_i,
  input  logic [1:0]       action_i,
  input  logic [7:0]       key_index_i,
  input  logic [7:0]       value_i,
  input  logic [8:0]       key_len_i,
  input  logic [9:0]       drop_cnt_i,
  output rc4_pkg::status_t st_o,
  output logic [7:0]       out_byte_o
);

  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [7:0]   i_q, j_q, a_q, b_q, t_q, k_q, n_q;
  logic [KW-1:0] pos_q, pos_d;
  logic [9:0]   drop_q;
  logic         dmode_q;
  logic [7:0]   value_q, kidx_q;
  logic [255:0] vld_q;
  logic         rvld_q;
  logic [7:0]   raddr_q;

  logic [7:0]   p_rdata, k_rdata, eff, kk;
  logic [7:0]   raddr, waddr, wdata;
  logic         we, key_we;
  logic [8:0]   pos_inc;

  // unwritten permutation entries read as their own index
  assign eff = rvld_q ? p_rdata : raddr_q;
  assign kk  = k_q + eff + k_rdata;

  always_comb begin
    unique case (ctl_i.rsel)
      rc4_pkg::R_I_NEXT: raddr = i_q + 8'd1;
      rc4_pkg::R_J_A:    raddr = j_q + eff;
      rc4_pkg::R_AB:     raddr = a_q + b_q;
      rc4_pkg::R_N:      raddr = n_q;
      rc4_pkg::R_KK:     raddr = kk;
      rc4_pkg::R_N_NEXT: raddr = n_q + 8'd1;
      default:           raddr = i_q;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = i_q;
    wdata = eff;
    unique case (ctl_i.wsel)
      rc4_pkg::W_I_B: begin
        waddr = i_q;
        wdata = eff;
      end
      rc4_pkg::W_J_A: begin
        waddr = j_q;
        wdata = a_q;
      end
      rc4_pkg::W_N_EFF: begin
        waddr = n_q;
        wdata = eff;
      end
      rc4_pkg::W_K_T: begin
        waddr = k_q;
        wdata = t_q;
      end
      default: we = 1'b0;
    endcase
  end

  // cyclic key position
  assign pos_inc = 9'(pos_q) + 9'd1;
  always_comb begin
    pos_d = pos_q;
    if (ctl_i.ks_init) begin
      pos_d = '0;
    end else if (ctl_i.step_n) begin
      pos_d = (pos_inc >= key_len_i) ? '0 : pos_inc[KW-1:0];
    end
  end

  assign key_we = ctl_i.key_we && ({1'b0, kidx_q} < 9'(MAX_KEY_BYTES));

  rc4_ram #(
    .WIDTH (8),
    .DEPTH (rc4_pkg::PERM_DEPTH)
  ) u_perm (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (p_rdata)
  );

  rc4_ram #(
    .WIDTH (8),
    .DEPTH (MAX_KEY_BYTES)
  ) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (kidx_q[KW-1:0]),
    .wdata_i (value_q),
    .raddr_i (pos_d),
    .rdata_o (k_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q     <= '0;
      j_q     <= '0;
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      dmode_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr] || (we && (waddr == raddr));
      if (ctl_i.ks_init) begin
        vld_q <= '0;
        i_q   <= '0;
        j_q   <= '0;
      end else begin
        if (we) begin
          vld_q[waddr] <= 1'b1;
        end
        if (ctl_i.inc_i) begin
          i_q <= i_q + 8'd1;
        end
        if (ctl_i.ld_aj) begin
          j_q <= j_q + eff;
        end
      end
      if (acc_i) begin
        dmode_q <= (action_i == rc4_pkg::A_DATA);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr;
    pos_q   <= pos_d;
    if (acc_i) begin
      value_q <= value_i;
      kidx_q  <= key_index_i;
    end
    if (ctl_i.ks_init) begin
      n_q    <= '0;
      k_q    <= '0;
      drop_q <= drop_cnt_i;
    end else begin
      if (ctl_i.step_n) begin
        n_q <= n_q + 8'd1;
      end
      if (ctl_i.ld_tk) begin
        t_q <= eff;
        k_q <= kk;
      end
      if (ctl_i.dec_drop) begin
        drop_q <= drop_q - 10'd1;
      end
    end
    if (ctl_i.ld_aj) begin
      a_q <= eff;
    end
    if (ctl_i.ld_b) begin
      b_q <= eff;
    end
  end

  assign st_o.dmode     = dmode_q;
  assign st_o.drop_zero = (drop_q == 10'd0);
  assign st_o.drop_one  = (drop_q == 10'd1);
  assign st_o.n_last    = (n_q == 8'hFF);

  assign out_byte_o = value_q ^ eff;

endmodule

// File: hw/rtl/rc4_stream_cipher_unit.sv
// -----------------------------------------------------------------------------
// RC4 stream cipher unit
// RC4 with keystream discard after key scheduling, microcode controlled.
// -----------------------------------------------------------------------------
// A beat on the input channel carries an action: load one key byte, run the
// key schedule (identity permutation, 256 mixing rounds with the key used
// cyclically over key_length bytes, indices cleared, then drop_count keystream
// bytes thrown away), or cipher one data byte, which gives exactly one output
// beat (value XOR keystream; the same operation encrypts and decrypts). Loads,
// schedules and the unused action give no output beat. A small microsequencer
// steps through a control store; all permutation traffic goes through one
// single-read-port memory, and that port sets the pace: a data byte runs the
// read/swap/read of one keystream step, hands the result over and returns to
// idle, and a schedule runs its mixing rounds, then one keystream step per
// dropped byte. The unit takes one item at a time; a finished output beat
// waits in its own register, so the next item is accepted while it is still
// stalled. The permutation needs no clearing pass: a valid bit per entry makes
// unwritten entries read as the identity, and a schedule clears them all at
// its start. Configuration is written through the plain write port; the user
// must write it only while the unit idles; the block does not enforce it.
// -----------------------------------------------------------------------------
`include "rc4_stream_cipher_unit_macros.svh"

module rc4_stream_cipher_unit #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write port
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [9:0] cfg_data_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] key_index_i,
  input  logic [7:0] value_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o
);

  logic [8:0] key_length_q;
  logic [9:0] drop_count_q;
  logic [8:0] key_len_eff;

  rc4_pkg::ctl_t    ctl;
  rc4_pkg::status_t st;
  logic             idle;
  logic             in_acc;
  logic             out_free;
  logic             out_ld;
  logic [7:0]       dp_byte;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= rc4_pkg::KEY_LENGTH_RST;
      drop_count_q <= rc4_pkg::DROP_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rc4_pkg::CFG_KEY_LENGTH: key_length_q <= cfg_data_i[8:0];
        rc4_pkg::CFG_DROP_COUNT: drop_count_q <= cfg_data_i;
        default:                 key_length_q <= key_length_q;
      endcase
    end
  end

  // zero length acts as one, oversize saturates to the key store depth
  always_comb begin
    key_len_eff = key_length_q;
    if (key_length_q == 9'd0) begin
      key_len_eff = 9'd1;
    end else if (key_length_q > 9'(MAX_KEY_BYTES)) begin
      key_len_eff = 9'(MAX_KEY_BYTES);
    end
  end

  // input side: one item at a time, taken only from idle
  assign in_stall_o = !idle;
  assign in_acc     = in_valid_i && !in_stall_o;

  // output register frees as its beat is taken
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_ld   = ctl.out_ld && st.dmode && out_free;

  rc4_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .action_i   (action_i),
    .st_i       (st),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .idle_o     (idle)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .acc_i       (in_acc),
    .action_i    (action_i),
    .key_index_i (key_index_i),
    .value_i     (value_i),
    .key_len_i   (key_len_eff),
    .drop_cnt_i  (drop_count_q),
    .st_o        (st),
    .out_byte_o  (dp_byte)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_ld) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_byte_q <= dp_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // any real work leaves idle on the next cycle
  `RC4_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc && (action_i != rc4_pkg::A_NOP), in_stall_o, "accepted item did not start the sequencer")
  // a handed-over result ends its item
  `RC4_ASSERT_NEXT(a_idle_after_result, clk_i, rst_ni, out_ld, idle, "sequencer busy after result beat")
  // a schedule with nothing to drop returns straight to idle
  `RC4_ASSERT_NEXT(a_no_drop_ends, clk_i, rst_ni, (ctl.cond == rc4_pkg::C_DROP_ZERO) && st.drop_zero, idle, "schedule did not end with zero drop count")
  // results only come out of the data path, never while idle
  `RC4_ASSERT_SAME(a_result_not_idle, clk_i, rst_ni, out_ld, !idle && !in_stall_o == 1'b0, "result produced from idle")

endmodule
